// File: rtl/julia_escape_time_pixel_core_macros.svh
// ----------------------------------------------------------------------------
// Julia escape-time pixel core: assertion macros
// Shared concurrent-check macros; define ASSERT_OFF to compile them away.
// ----------------------------------------------------------------------------
`ifndef JULIA_ESCAPE_TIME_PIXEL_CORE_MACROS_SVH
`define JULIA_ESCAPE_TIME_PIXEL_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset
`define JET_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jet: same-cycle check failed");
// Next-cycle implication, disabled during reset
`define JET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jet: next-cycle check failed");
`else
`define JET_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define JET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/jet_pkg.sv
// ----------------------------------------------------------------------------
// Julia escape-time pixel core: shared package
// Field widths, register indexes, configuration bundle and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package jet_pkg;

    localparam int PIX_W      = 10;
    localparam int WIN_W      = 28;
    localparam int CONST_W    = 27;
    localparam int LIMIT_W    = 10;
    localparam int GAIN_W     = 16;
    localparam int COLOR_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Derived arithmetic widths
    localparam int SPAN_W = WIN_W + 1;
    localparam int PROD_W = PIX_W + SPAN_W;
    localparam int MAP_W  = PROD_W + 2;
    localparam int NSQ_W  = 2 * LIMIT_W;

    // Register reset values that do not depend on the fraction width
    localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(250);
    localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(265);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RE_MIN = 3'd0,
        CFG_RE_MAX = 3'd1,
        CFG_IM_MIN = 3'd2,
        CFG_IM_MAX = 3'd3,
        CFG_C_RE   = 3'd4,
        CFG_C_IM   = 3'd5,
        CFG_LIMIT  = 3'd6,
        CFG_GAIN   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [WIN_W-1:0]   re_min;
        logic [WIN_W-1:0]   re_max;
        logic [WIN_W-1:0]   im_min;
        logic [WIN_W-1:0]   im_max;
        logic [CONST_W-1:0] c_re;
        logic [CONST_W-1:0] c_im;
        logic [LIMIT_W-1:0] limit;
        logic [GAIN_W-1:0]  gain;
    } cfg_t;

    // Source of the final iteration count
    typedef enum logic [1:0] {
        N_ZERO = 2'd0,
        N_ITER = 2'd1,
        N_PREV = 2'd2
    } n_sel_t;

    typedef struct packed {
        logic   in_load;
        logic   span;
        logic   div_start;
        logic   init;
        logic   step;
        logic   n_load;
        n_sel_t n_sel;
        logic   n_square;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_idle;
        logic big;
        logic sq_esc;
        logic box_esc;
        logic at_limit;
    } dp_status_t;

endpackage

// File: rtl/jet_div.sv
// ----------------------------------------------------------------------------
// Julia escape-time pixel core: constant divider
// Division of an unsigned dividend by a fixed divisor through multiplication
// by its scaled reciprocal, one reciprocal digit per cycle, most significant
// digit first.
// ----------------------------------------------------------------------------
module jet_div #(
    parameter int DIVISOR = 1024,
    parameter int NUM_W   = 39
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    output logic [NUM_W-1:0] quotient,
    output logic             idle
);

    // Reciprocal rounded up at NUM_W + log2 bits of scale gives the exact
    // floor quotient for every NUM_W-bit dividend.
    localparam int LOG_W  = $clog2(DIVISOR);
    localparam int SHIFT  = NUM_W + LOG_W;
    localparam int DIG_W  = 10;
    localparam int DIGITS = (NUM_W + 1 + DIG_W - 1) / DIG_W;
    localparam int RCP_W  = DIGITS * DIG_W;
    localparam int ACC_W  = NUM_W + RCP_W;
    localparam int PART_W = NUM_W + DIG_W;
    localparam int CNT_W  = $clog2(DIGITS + 1);
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic [NUM_W-1:0]  num_reg, num_next;
    logic [RCP_W-1:0]  rcp_reg, rcp_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [PART_W-1:0] part;

    // Multiply the held dividend by the top reciprocal digit
    always_comb
    begin
        part = num_reg * rcp_reg[RCP_W-1 -: DIG_W];
    end

    // Load on start, otherwise fold in one digit while busy
    always_comb
    begin
        num_next  = num_reg;
        rcp_next  = rcp_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            num_next  = dividend;
            rcp_next  = RECIP;
            acc_next  = '0;
            cnt_next  = CNT_W'(DIGITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next  = (acc_reg << DIG_W) + ACC_W'(part);
            rcp_next  = rcp_reg << DIG_W;
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    // Hold the sequencing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    // Hold the operands and the running product
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rcp_reg <= rcp_next;
        acc_reg <= acc_next;
    end

    assign quotient = NUM_W'(acc_reg[ACC_W-1:SHIFT]);
    assign idle     = !busy_reg;

endmodule

// File: rtl/jet_datapath.sv
// ----------------------------------------------------------------------------
// Julia escape-time pixel core: datapath
// Window mapping, the complex squaring step with escape tests, the iteration
// count and the colour product, all driven by controller commands.
// ----------------------------------------------------------------------------
`include "julia_escape_time_pixel_core_macros.svh"

module jet_datapath
    import jet_pkg::*;
#(
    parameter int WIDTH     = 1024,
    parameter int HEIGHT    = 1024,
    parameter int FRAC_BITS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    input  logic [PIX_W-1:0]   in_px,
    input  logic [PIX_W-1:0]   in_py,
    output logic [PIX_W-1:0]   out_px,
    output logic [PIX_W-1:0]   out_py,
    output logic [COLOR_W-1:0] pixel_color
);

    // A start point at or beyond +/-2^LT escapes on its first update, so the
    // iteration registers only need to cover that range.
    localparam int EXP_C = CONST_W - 1 - FRAC_BITS;
    localparam int LT    = (EXP_C <= 2) ? 2 : ((EXP_C + 1) / 2 + 1);
    localparam int ZW    = FRAC_BITS + LT + 1;
    localparam int NW    = FRAC_BITS + 2 * LT + 3;
    localparam int PW    = 2 * ZW;

    localparam logic signed [NW-1:0]    TWO_N     = NW'(64'd2 << FRAC_BITS);
    localparam logic signed [NW-1:0]    NEG_TWO_N = NW'(64'd0 - (64'd2 << FRAC_BITS));
    localparam logic signed [NW-1:0]    FOUR_N    = NW'(64'd4 << FRAC_BITS);
    localparam logic signed [ZW-1:0]    TWO_Z     = ZW'(64'd2 << FRAC_BITS);
    localparam logic signed [ZW-1:0]    NEG_TWO_Z = ZW'(64'd0 - (64'd2 << FRAC_BITS));
    localparam logic signed [MAP_W-1:0] BIG_M     = MAP_W'(64'd1 << (FRAC_BITS + LT));
    localparam logic signed [MAP_W-1:0] NEG_BIG_M =
        MAP_W'(64'd0 - (64'd1 << (FRAC_BITS + LT)));

    logic [PIX_W-1:0]         px_reg, py_reg;
    logic [SPAN_W-1:0]        re_abs_reg, im_abs_reg;
    logic                     re_neg_reg, im_neg_reg;
    logic signed [ZW-1:0]     z_re_reg, z_im_reg;
    logic [LIMIT_W-1:0]       k_reg;
    logic [LIMIT_W-1:0]       n_reg;
    logic [NSQ_W-1:0]         nsq_reg;
    logic [PIX_W-1:0]         out_px_reg, out_py_reg;
    logic [COLOR_W-1:0]       out_color_reg;

    logic signed [SPAN_W-1:0] span_re, span_im;
    logic [PROD_W-1:0]        dvd_re, dvd_im;
    logic [PROD_W-1:0]        q_re, q_im;
    logic                     idle_re, idle_im;
    logic [MAP_W-1:0]         q_re_ext, q_im_ext;
    logic signed [MAP_W-1:0]  off_re, off_im;
    logic signed [MAP_W-1:0]  lo_re, lo_im;
    logic signed [MAP_W-1:0]  z0_re, z0_im;

    logic signed [PW-1:0]     p_rr, p_ii, p_ri;
    logic signed [NW-1:0]     rr, ii, ri;
    logic signed [NW-1:0]     c_re_ext, c_im_ext;
    logic signed [NW-1:0]     nr, ni, sq;
    logic [NSQ_W+GAIN_W-1:0]  color_full;
    logic [LIMIT_W-1:0]       n_sel_val;

    // Window spans, sign and magnitude
    assign span_re = $signed({cfg.re_max[WIN_W-1], cfg.re_max})
                   - $signed({cfg.re_min[WIN_W-1], cfg.re_min});
    assign span_im = $signed({cfg.im_max[WIN_W-1], cfg.im_max})
                   - $signed({cfg.im_min[WIN_W-1], cfg.im_min});

    // Pixel times span feeds the dividers
    assign dvd_re = px_reg * re_abs_reg;
    assign dvd_im = py_reg * im_abs_reg;

    jet_div #(
        .DIVISOR (WIDTH),
        .NUM_W   (PROD_W)
    ) u_div_re (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd_re),
        .quotient (q_re),
        .idle     (idle_re)
    );

    jet_div #(
        .DIVISOR (HEIGHT),
        .NUM_W   (PROD_W)
    ) u_div_im (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd_im),
        .quotient (q_im),
        .idle     (idle_im)
    );

    // Start point: lower edge plus signed quotient (truncated toward zero)
    always_comb
    begin
        q_re_ext = {2'b00, q_re};
        q_im_ext = {2'b00, q_im};
        off_re   = re_neg_reg ? -$signed(q_re_ext) : $signed(q_re_ext);
        off_im   = im_neg_reg ? -$signed(q_im_ext) : $signed(q_im_ext);
        lo_re    = $signed({{(MAP_W - WIN_W){cfg.re_min[WIN_W-1]}}, cfg.re_min});
        lo_im    = $signed({{(MAP_W - WIN_W){cfg.im_min[WIN_W-1]}}, cfg.im_min});
        z0_re    = lo_re + off_re;
        z0_im    = lo_im + off_im;
    end

    // Complex squaring step
    always_comb
    begin
        p_rr     = z_re_reg * z_re_reg;
        p_ii     = z_im_reg * z_im_reg;
        p_ri     = z_re_reg * z_im_reg;
        rr       = NW'(p_rr >>> FRAC_BITS);
        ii       = NW'(p_ii >>> FRAC_BITS);
        ri       = NW'(p_ri >>> (FRAC_BITS - 1));
        c_re_ext = $signed({{(NW - CONST_W){cfg.c_re[CONST_W-1]}}, cfg.c_re});
        c_im_ext = $signed({{(NW - CONST_W){cfg.c_im[CONST_W-1]}}, cfg.c_im});
        nr       = rr - ii + c_re_ext;
        ni       = ri - c_im_ext;
        sq       = rr + ii;
    end

    // Status back to the controller
    always_comb
    begin
        status.div_idle = idle_re && idle_im;
        status.big      = (z0_re >= BIG_M) || (z0_re <= NEG_BIG_M)
                       || (z0_im >= BIG_M) || (z0_im <= NEG_BIG_M);
        status.sq_esc   = (k_reg != '0) && (sq > FOUR_N);
        status.box_esc  = (nr > TWO_N) || (nr < NEG_TWO_N)
                       || (ni > TWO_N) || (ni < NEG_TWO_N);
        status.at_limit = (k_reg == cfg.limit);
    end

    // Pick the completed iteration count
    always_comb
    begin
        case (cmd.n_sel)
            N_ZERO:  n_sel_val = '0;
            N_ITER:  n_sel_val = k_reg;
            N_PREV:  n_sel_val = k_reg - LIMIT_W'(1);
            default: n_sel_val = '0;
        endcase
    end

    assign color_full = nsq_reg * cfg.gain;

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            px_reg <= in_px;
            py_reg <= in_py;
        end
        if (cmd.span)
        begin
            re_neg_reg <= span_re[SPAN_W-1];
            im_neg_reg <= span_im[SPAN_W-1];
            re_abs_reg <= span_re[SPAN_W-1] ? SPAN_W'(-span_re) : SPAN_W'(span_re);
            im_abs_reg <= span_im[SPAN_W-1] ? SPAN_W'(-span_im) : SPAN_W'(span_im);
        end
        if (cmd.init)
        begin
            z_re_reg <= ZW'(z0_re);
            z_im_reg <= ZW'(z0_im);
            k_reg    <= '0;
        end
        else if (cmd.step)
        begin
            z_re_reg <= ZW'(nr);
            z_im_reg <= ZW'(ni);
            k_reg    <= k_reg + LIMIT_W'(1);
        end
        if (cmd.n_load)
            n_reg <= n_sel_val;
        if (cmd.n_square)
            nsq_reg <= n_reg * n_reg;
        if (cmd.out_load)
        begin
            out_px_reg    <= px_reg;
            out_py_reg    <= py_reg;
            out_color_reg <= color_full[COLOR_W-1:0];
        end
    end

    assign out_px      = out_px_reg;
    assign out_py      = out_py_reg;
    assign pixel_color = out_color_reg;

    // An accepted step always leaves z inside the escape box
    `JET_ASSERT_NEXT(a_step_in_box, clk, rst_n, cmd.step, (z_re_reg <= TWO_Z) && (z_re_reg >= NEG_TWO_Z) && (z_im_reg <= TWO_Z) && (z_im_reg >= NEG_TWO_Z))
    // A step is only taken below the iteration limit
    `JET_ASSERT_IMPLY(a_step_below_limit, clk, rst_n, cmd.step, k_reg < cfg.limit)

endmodule

// File: rtl/jet_ctrl.sv
// ----------------------------------------------------------------------------
// Julia escape-time pixel core: controller
// Sequences one pixel through span set-up, mapping division, iteration and
// colour, and owns the request handshakes and the output valid flag.
// ----------------------------------------------------------------------------
`include "julia_escape_time_pixel_core_macros.svh"

module jet_ctrl
    import jet_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SPAN  = 8'b0000_0010,
        S_PROD  = 8'b0000_0100,
        S_DIV   = 8'b0000_1000,
        S_START = 8'b0001_0000,
        S_ITER  = 8'b0010_0000,
        S_SQ    = 8'b0100_0000,
        S_GAIN  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.n_sel  = N_ZERO;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = S_SPAN;
                end
            end
            S_SPAN:
            begin
                cmd.span   = 1'b1;
                state_next = S_PROD;
            end
            S_PROD:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_idle)
                    state_next = S_START;
            end
            S_START:
            begin
                cmd.init = 1'b1;
                if (status.big)
                begin
                    cmd.n_load = 1'b1;
                    cmd.n_sel  = N_ZERO;
                    state_next = S_SQ;
                end
                else
                    state_next = S_ITER;
            end
            S_ITER:
            begin
                if (status.sq_esc)
                begin
                    cmd.n_load = 1'b1;
                    cmd.n_sel  = N_PREV;
                    state_next = S_SQ;
                end
                else if (status.at_limit)
                begin
                    cmd.n_load = 1'b1;
                    cmd.n_sel  = N_ZERO;
                    state_next = S_SQ;
                end
                else if (status.box_esc)
                begin
                    cmd.n_load = 1'b1;
                    cmd.n_sel  = N_ITER;
                    state_next = S_SQ;
                end
                else
                    cmd.step = 1'b1;
            end
            S_SQ:
            begin
                cmd.n_square = 1'b1;
                state_next   = S_GAIN;
            end
            S_GAIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Raise on load, drop once the result request is taken
    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // A new result never overwrites one still waiting
    `JET_ASSERT_IMPLY(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid_reg || out_ready)
    // An accepted request moves straight on to span set-up
    `JET_ASSERT_NEXT(a_accept_span, clk, rst_n, in_valid && in_ready, state_reg == S_SPAN)
    // Starting the dividers makes them busy in the next cycle
    `JET_ASSERT_NEXT(a_div_runs, clk, rst_n, cmd.div_start, !status.div_idle)

endmodule

// File: rtl/julia_escape_time_pixel_core.sv
// ----------------------------------------------------------------------------
// Julia escape-time pixel core: top level
// Configuration registers, controller and datapath for one pixel at a time.
// ----------------------------------------------------------------------------
// One pixel is in flight at a time. After a request is accepted the core
// goes through set-up (the accepting cycle, span and product), the window
// mapping, in which the two reciprocal multipliers take one 10-bit
// reciprocal digit per cycle and the controller waits until both are idle,
// loading of the start point, then one pass of the complex squaring unit
// per cycle until the pixel escapes or reaches iteration_limit (a start
// point far outside the escape radius skips the loop), and the colour
// product, in which the count is squared and then scaled by the gain. A
// waiting result can hold the pixel in the colour stage. The result
// sits in an output register, so the next request is taken as soon as the
// result has been loaded, even while it waits to be read.
// ----------------------------------------------------------------------------
module julia_escape_time_pixel_core
    import jet_pkg::*;
#(
    parameter int WIDTH     = 1024,
    parameter int HEIGHT    = 1024,
    parameter int FRAC_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIX_W-1:0]      px,
    input  logic [PIX_W-1:0]      py,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_W-1:0]      out_px,
    output logic [PIX_W-1:0]      out_py,
    output logic [COLOR_W-1:0]    pixel_color
);

    localparam logic [WIN_W-1:0] WIN_POS_RST = WIN_W'(64'd2 << FRAC_BITS);
    localparam logic [WIN_W-1:0] WIN_NEG_RST = WIN_W'(64'd0 - (64'd2 << FRAC_BITS));

    cfg_t       cfg_reg;
    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.re_min <= WIN_NEG_RST;
            cfg_reg.re_max <= WIN_POS_RST;
            cfg_reg.im_min <= WIN_NEG_RST;
            cfg_reg.im_max <= WIN_POS_RST;
            cfg_reg.c_re   <= '0;
            cfg_reg.c_im   <= '0;
            cfg_reg.limit  <= LIMIT_RST;
            cfg_reg.gain   <= GAIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_RE_MIN: cfg_reg.re_min <= cfg_data[WIN_W-1:0];
                CFG_RE_MAX: cfg_reg.re_max <= cfg_data[WIN_W-1:0];
                CFG_IM_MIN: cfg_reg.im_min <= cfg_data[WIN_W-1:0];
                CFG_IM_MAX: cfg_reg.im_max <= cfg_data[WIN_W-1:0];
                CFG_C_RE:   cfg_reg.c_re   <= cfg_data[CONST_W-1:0];
                CFG_C_IM:   cfg_reg.c_im   <= cfg_data[CONST_W-1:0];
                CFG_LIMIT:  cfg_reg.limit  <= cfg_data[LIMIT_W-1:0];
                CFG_GAIN:   cfg_reg.gain   <= cfg_data[GAIN_W-1:0];
                default:    cfg_reg        <= cfg_reg;
            endcase
        end
    end

    jet_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    jet_datapath #(
        .WIDTH     (WIDTH),
        .HEIGHT    (HEIGHT),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .cmd         (cmd),
        .status      (status),
        .in_px       (px),
        .in_py       (py),
        .out_px      (out_px),
        .out_py      (out_py),
        .pixel_color (pixel_color)
    );

endmodule
